[hw/rtl/nvq_pkg.sv]
package nvq_pkg;

  // Width of the fixed-point sums. Every sum stays within 27 signed bits.
  localparam int SUM_W = 28;
  localparam int SHIFT = 16;
  localparam int COEF_W = 19;
  localparam int DIFF_W = 9;
  localparam int Q_W = SUM_W - SHIFT;

  localparam logic signed [COEF_W-1:0] COEF_RV = 19'sd104597;
  localparam logic signed [COEF_W-1:0] COEF_BU = 19'sd132201;
  localparam logic signed [COEF_W-1:0] COEF_GU = 19'sd25675;
  localparam logic signed [COEF_W-1:0] COEF_GV = 19'sd53279;
  localparam logic signed [COEF_W-1:0] COEF_Y  = 19'sd76309;
  localparam logic [DIFF_W-1:0] CHROMA_MID = 9'd128;
  localparam logic [DIFF_W-1:0] LUMA_BLACK = 9'd16;

  localparam logic ORDER_NV12 = 1'b0;
  localparam logic ORDER_NV21 = 1'b1;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_first;
    logic [7:0] chroma_second;
  } quad_in_t;

  typedef struct packed {
    logic [7:0] red_top_left;
    logic [7:0] green_top_left;
    logic [7:0] blue_top_left;
    logic [7:0] red_top_right;
    logic [7:0] green_top_right;
    logic [7:0] blue_top_right;
    logic [7:0] red_bottom_left;
    logic [7:0] green_bottom_left;
    logic [7:0] blue_bottom_left;
    logic [7:0] red_bottom_right;
    logic [7:0] green_bottom_right;
    logic [7:0] blue_bottom_right;
  } quad_out_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } stage_en_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] cr;
    logic signed [SUM_W-1:0] cg;
    logic signed [SUM_W-1:0] cb;
  } chroma_terms_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

[hw/rtl/nvq_chroma.sv]
module nvq_chroma (
  input  logic                   clk,
  input  nvq_pkg::stage_en_t     en,
  input  logic                   chroma_order,
  input  logic [7:0]             chroma_first,
  input  logic [7:0]             chroma_second,
  output nvq_pkg::chroma_terms_t terms
);
  import nvq_pkg::*;

  logic [7:0]               u_raw, v_raw;
  logic signed [DIFF_W-1:0] u_d, v_d;
  logic signed [SUM_W-1:0]  u_x, v_x;
  logic signed [SUM_W-1:0]  cr_nxt, cg_nxt, cb_nxt;
  logic signed [SUM_W-1:0]  cr_r, cg_r, cb_r;

  always_comb begin
    if (chroma_order == ORDER_NV21) begin
      v_raw = chroma_first;
      u_raw = chroma_second;
    end else begin
      u_raw = chroma_first;
      v_raw = chroma_second;
    end
    u_d = $signed({1'b0, u_raw} - CHROMA_MID);
    v_d = $signed({1'b0, v_raw} - CHROMA_MID);
    u_x = SUM_W'(u_d);
    v_x = SUM_W'(v_d);
    cr_nxt = SUM_W'(v_x * SUM_W'(COEF_RV));
    cg_nxt = SUM_W'(u_x * SUM_W'(COEF_GU)) + SUM_W'(v_x * SUM_W'(COEF_GV));
    cb_nxt = SUM_W'(u_x * SUM_W'(COEF_BU));
  end

  always_ff @(posedge clk) begin
    if (en.s1_en) begin
      cr_r <= cr_nxt;
      cg_r <= cg_nxt;
      cb_r <= cb_nxt;
    end
  end

  assign terms = '{cr: cr_r, cg: cg_r, cb: cb_r};

endmodule

[hw/rtl/nvq_lane.sv]
module nvq_lane (
  input  logic                   clk,
  input  nvq_pkg::stage_en_t     en,
  input  logic [7:0]             luma,
  input  nvq_pkg::chroma_terms_t terms,
  output nvq_pkg::rgb_t          rgb
);
  import nvq_pkg::*;

  logic signed [DIFF_W-1:0] y_d;
  logic signed [SUM_W-1:0]  y_nxt, y_r;
  logic signed [SUM_W-1:0]  sum_r, sum_g, sum_b;
  rgb_t                     rgb_nxt, rgb_r;

  // Floor of sum / 65536, saturated to a byte.
  function automatic logic [7:0] to_byte(input logic signed [SUM_W-1:0] sum);
    logic [Q_W-1:0] q;
    q = sum[SUM_W-1:SHIFT];
    if (q[Q_W-1]) begin
      to_byte = 8'd0;
    end else if (|q[Q_W-2:8]) begin
      to_byte = 8'd255;
    end else begin
      to_byte = q[7:0];
    end
  endfunction

  assign y_d   = $signed({1'b0, luma} - LUMA_BLACK);
  assign y_nxt = SUM_W'(SUM_W'(y_d) * SUM_W'(COEF_Y));

  always_ff @(posedge clk) begin
    if (en.s1_en) begin
      y_r <= y_nxt;
    end
  end

  always_comb begin
    sum_r = y_r + terms.cr;
    sum_g = y_r - terms.cg;
    sum_b = y_r + terms.cb;
    rgb_nxt.red   = to_byte(sum_r);
    rgb_nxt.green = to_byte(sum_g);
    rgb_nxt.blue  = to_byte(sum_b);
  end

  always_ff @(posedge clk) begin
    if (en.s2_en) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign rgb = rgb_r;

endmodule

[hw/rtl/nv12_nv21_to_rgb_quad.sv]
// Converts one 2x2 quad of an NV12 or NV21 frame into four RGB pixels with
// BT.601 limited-range fixed-point coefficients.
// Input channel: in_valid / in_ready with in_data carrying the four luma
// samples and the two interleaved chroma bytes of the quad.
// Output channel: out_valid / out_ready with out_data carrying the clamped
// red, green and blue bytes of all four pixels.
// cfg_write_en and cfg_write_data set the chroma order (0 is NV12, U first;
// 1 is NV21, V first). Write it only while no request is in flight.
// Requests pass through two register stages, multiply and sum/clamp, before
// they show on out_data. Throughput is one quad per cycle while the receiver
// takes results; the chroma terms are shared by four pixel lanes, and the rate
// is set by the two-stage multiply and sum/clamp pipeline, each stage holding one quad.
// Reset clears both stage valid flags and sets NV12 order. When the receiver
// stalls, the output stage holds its result and the first stage still takes
// one more request, so in_ready falls only when both stages are full.
module nv12_nv21_to_rgb_quad (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nvq_pkg::quad_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nvq_pkg::quad_out_t out_data,
  input  logic               cfg_write_en,
  input  logic               cfg_write_data
);
  import nvq_pkg::*;

  logic          order_r, order_nxt;
  logic          v1_r, v1_nxt, v2_r, v2_nxt;
  logic          adv;
  stage_en_t     en;
  chroma_terms_t terms;
  rgb_t          tl, tr, bl, br;

  assign adv      = !v2_r || out_ready;
  assign in_ready = !v1_r || adv;
  assign en.s1_en = in_valid && in_ready;
  assign en.s2_en = v1_r && adv;

  always_comb begin
    order_nxt = cfg_write_en ? cfg_write_data : order_r;
    v1_nxt    = in_ready ? in_valid : v1_r;
    v2_nxt    = adv ? v1_r : v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_NV12;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      order_r <= order_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
    end
  end

  nvq_chroma u_chroma (
    .clk           (clk),
    .en            (en),
    .chroma_order  (order_r),
    .chroma_first  (in_data.chroma_first),
    .chroma_second (in_data.chroma_second),
    .terms         (terms)
  );

  nvq_lane u_lane_tl (.clk(clk), .en(en), .luma(in_data.luma_top_left),
                      .terms(terms), .rgb(tl));
  nvq_lane u_lane_tr (.clk(clk), .en(en), .luma(in_data.luma_top_right),
                      .terms(terms), .rgb(tr));
  nvq_lane u_lane_bl (.clk(clk), .en(en), .luma(in_data.luma_bottom_left),
                      .terms(terms), .rgb(bl));
  nvq_lane u_lane_br (.clk(clk), .en(en), .luma(in_data.luma_bottom_right),
                      .terms(terms), .rgb(br));

  // The lane outputs are the output register; gather them into the quad.
  always_comb begin
    out_data.red_top_left       = tl.red;
    out_data.green_top_left     = tl.green;
    out_data.blue_top_left      = tl.blue;
    out_data.red_top_right      = tr.red;
    out_data.green_top_right    = tr.green;
    out_data.blue_top_right     = tr.blue;
    out_data.red_bottom_left    = bl.red;
    out_data.green_bottom_left  = bl.green;
    out_data.blue_bottom_left   = bl.blue;
    out_data.red_bottom_right   = br.red;
    out_data.green_bottom_right = br.green;
    out_data.blue_bottom_right  = br.blue;
  end

  assign out_valid = v2_r;

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && !out_ready))
    else $error("in_ready low while the pipeline has room");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted request did not reach the first stage");

  a_s1_moves_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && adv) |=> out_valid)
    else $error("first stage result was lost on its way to the output");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!v1_r && !v2_r))
    else $error("pipeline not empty after reset");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import nvq_pkg::*;

  // BT.601 limited-range coefficients, scaled by 65536.
  localparam int K_RV = 104597;
  localparam int K_BU = 132201;
  localparam int K_GU = 25675;
  localparam int K_GV = 53279;
  localparam int K_Y = 76309;
  localparam int MID_CHROMA = 128;
  localparam int BLACK_LEVEL = 16;

  localparam int QUADS_PER_PHASE = 545;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic       order;
    quad_in_t   quad;
    bit         fixed;
    logic [7:0] fixed_byte;
  } vector_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  quad_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  quad_out_t out_data;
  logic      cfg_write_en;
  logic      cfg_write_data;

  logic      model_order;
  quad_out_t rgb_pending[$];
  vector_t   vectors[$];
  int        errors = 0;
  int        cycles = 0;
  int        send_idle_pct = 28;
  int        recv_idle_pct = 66;
  int        phase = -1;
  int        sent_in_phase = 0;
  logic      hold_off = 1'b0;

  nv12_nv21_to_rgb_quad DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] clamp_byte(int sum);
    int q;
    // Arithmetic shift of a signed int floors toward minus infinity.
    q = sum >>> 16;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  function automatic quad_out_t quad_to_rgb(quad_in_t q, logic order);
    int         u;
    int         v;
    int         cr;
    int         cg;
    int         cb;
    int         y;
    logic [7:0] lumas [4];
    quad_out_t  r;
    if (order == ORDER_NV12) begin
      u = int'(q.chroma_first);
      v = int'(q.chroma_second);
    end else begin
      v = int'(q.chroma_first);
      u = int'(q.chroma_second);
    end
    u = u - MID_CHROMA;
    v = v - MID_CHROMA;
    cr = K_RV * v;
    cg = K_GU * u + K_GV * v;
    cb = K_BU * u;
    lumas[0] = q.luma_top_left;
    lumas[1] = q.luma_top_right;
    lumas[2] = q.luma_bottom_left;
    lumas[3] = q.luma_bottom_right;
    for (int k = 0; k < 4; k++) begin
      y = K_Y * (int'(lumas[k]) - BLACK_LEVEL);
      r[95-24*k -: 24] = {clamp_byte(y + cr), clamp_byte(y - cg), clamp_byte(y + cb)};
    end
    return r;
  endfunction

  function automatic vector_t mk_row(logic ord, logic [7:0] ytl, logic [7:0] ytr,
                                     logic [7:0] ybl, logic [7:0] ybr,
                                     logic [7:0] c1, logic [7:0] c2,
                                     bit fixed, logic [7:0] fb);
    vector_t row;
    row.order = ord;
    row.quad = {ytl, ytr, ybl, ybr, c1, c2};
    row.fixed = fixed;
    row.fixed_byte = fb;
    return row;
  endfunction

  task automatic add_rows(logic ord);
    // Black level and below with neutral chroma give black; full luma gives white.
    vectors.push_back(mk_row(ord, 16, 16, 16, 16, 128, 128, 1'b1, 8'd0));
    vectors.push_back(mk_row(ord, 0, 0, 0, 0, 128, 128, 1'b1, 8'd0));
    vectors.push_back(mk_row(ord, 255, 255, 255, 255, 128, 128, 1'b1, 8'd255));
    vectors.push_back(mk_row(ord, 0, 0, 0, 0, 0, 0, 1'b0, 8'd0));
    vectors.push_back(mk_row(ord, 255, 255, 255, 255, 255, 255, 1'b0, 8'd0));
    vectors.push_back(mk_row(ord, 255, 255, 255, 255, 0, 0, 1'b0, 8'd0));
    vectors.push_back(mk_row(ord, 0, 0, 0, 0, 255, 255, 1'b0, 8'd0));
    vectors.push_back(mk_row(ord, 0, 255, 16, 235, 0, 255, 1'b0, 8'd0));
    vectors.push_back(mk_row(ord, 0, 255, 16, 235, 255, 0, 1'b0, 8'd0));
    vectors.push_back(mk_row(ord, 128, 128, 128, 128, 128, 0, 1'b0, 8'd0));
    vectors.push_back(mk_row(ord, 128, 128, 128, 128, 0, 128, 1'b0, 8'd0));
    vectors.push_back(mk_row(ord, 235, 16, 128, 64, 240, 16, 1'b0, 8'd0));
  endtask

  function automatic logic [7:0] edge_byte();
    return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 24))
                                       : 8'($urandom_range(231, 255));
  endfunction

  function automatic quad_in_t random_quad();
    quad_in_t q;
    int       kind;
    q = quad_in_t'({$urandom(), $urandom()});
    kind = $urandom_range(0, 9);
    // Push some quads toward the clamp limits on luma or chroma.
    if (kind >= 6 && kind <= 7) begin
      q.luma_top_left = edge_byte();
      q.luma_top_right = edge_byte();
      q.luma_bottom_left = edge_byte();
      q.luma_bottom_right = edge_byte();
    end else if (kind >= 8) begin
      q.chroma_first = edge_byte();
      q.chroma_second = edge_byte();
    end
    return q;
  endfunction

  task automatic offer_quad(quad_in_t q, quad_out_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (!in_ready);
    rgb_pending.push_back(want);
    sent_in_phase++;
  endtask

  task automatic set_order(logic ord);
    in_valid <= 1'b0;
    while (rgb_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= ord;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    model_order = ord;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Long receiver stall while the sender keeps offering quads.
  initial begin
    wait (phase == 2 && sent_in_phase >= 100);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : check_rgb
    quad_out_t  want;
    logic [7:0] exp_byte;
    logic [7:0] got_byte;
    if (rst_n && out_valid && out_ready) begin
      if (rgb_pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result with no request outstanding at cycle %0d: %h", cycles, out_data);
      end else begin
        want = rgb_pending.pop_front();
        for (int i = 0; i < 12; i++) begin
          exp_byte = want[95-8*i -: 8];
          got_byte = out_data[95-8*i -: 8];
          if (got_byte !== exp_byte) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("mismatch at cycle %0d, pixel %0d %s: expected %0d, got %0d",
                       cycles, i / 3,
                       (i % 3 == 0) ? "red" : (i % 3 == 1) ? "green" : "blue",
                       exp_byte, got_byte);
          end
        end
      end
    end
  end

  initial begin
    vector_t   row;
    quad_in_t  q;
    quad_out_t want;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_write_en = 1'b0;
    cfg_write_data = ORDER_NV12;
    model_order = ORDER_NV12;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_rows(ORDER_NV12);
    add_rows(ORDER_NV21);
    foreach (vectors[i]) begin
      row = vectors[i];
      if (row.order != model_order) set_order(row.order);
      want = row.fixed ? quad_out_t'({12{row.fixed_byte}}) : quad_to_rgb(row.quad, model_order);
      offer_quad(row.quad, want);
    end

    for (int p = 0; p < 3; p++) begin
      set_order((p == 0) ? ORDER_NV21 : (p == 1) ? ORDER_NV12 : logic'($urandom_range(0, 1)));
      send_idle_pct = (p == 0) ? 28 : (p == 1) ? 66 : 0;
      recv_idle_pct = (p == 0) ? 66 : (p == 1) ? 28 : 0;
      sent_in_phase = 0;
      phase = p;
      repeat (QUADS_PER_PHASE) begin
        q = random_quad();
        offer_quad(q, quad_to_rgb(q, model_order));
      end
    end

    in_valid <= 1'b0;
    while (rgb_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
